### rtl/b64sd_pkg.sv
package b64sd_pkg;

  // padding character
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // result of an alphabet lookup
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  // one result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic       failed;
  } result_t;

  // standard alphabet with '+' and '/'
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.valid = 1'b1;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/base64_strict_decoder.sv
// Strict Base64 decoder: one character per input item (tdata = character, tlast marks the
// last character of a message), standard alphabet with '+' and '/'. A decoded byte is sent as
// soon as eight bits are collected; these bytes are tentative. Padding must close the final
// quad, the bits it leaves unused must be zero, and the message length must be a multiple of
// four; any violation is sticky, suppresses further bytes, and the item that closes the
// message (tlast) reports failed in tuser[1]. One input item is taken every cycle while the
// skid stage is empty: the decode is a table lookup and a shift done in the cycle of
// acceptance, and results leave through an output register backed by a one-item skid stage,
// so input tready depends only on that stage. Empty messages are not handled.
module base64_strict_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tlast,   // final_symbol
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] failed
  output logic       m_axis_tlast    // end_of_message
);

  // decoder state
  logic [11:0] bit_store;
  logic [3:0]  bits_held;
  logic [1:0]  quad_position;
  logic [1:0]  pad_seen;
  logic [5:0]  prior_sextet;
  logic        error_flag;

  logic [11:0] bit_store_next;
  logic [3:0]  bits_held_next;
  logic [1:0]  pad_seen_next;
  logic [5:0]  prior_sextet_next;
  logic        error_flag_next;

  // output register and skid stage
  logic              out_valid;
  b64sd_pkg::result_t out_item;
  logic              skid_valid;
  b64sd_pkg::result_t skid_item;

  b64sd_pkg::sextet_t  sx;
  b64sd_pkg::result_t  res;
  logic                have_byte;
  logic [7:0]          shifted;
  logic                accept;
  logic                push;
  logic                fin;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fin           = s_axis_tlast;
  assign sx            = b64sd_pkg::sextet_of(s_axis_tdata);

  // per-character decode and strict checks
  always_comb begin
    bit_store_next    = bit_store;
    bits_held_next    = bits_held;
    pad_seen_next     = pad_seen;
    prior_sextet_next = prior_sextet;
    error_flag_next   = error_flag;
    have_byte         = 1'b0;
    shifted           = '0;
    if (!error_flag) begin
      if (s_axis_tdata == b64sd_pkg::PAD_CHAR) begin
        if (pad_seen == 2'd0) begin
          if (quad_position == 2'd2) begin
            if (prior_sextet[3:0] != 4'd0) error_flag_next = 1'b1;
          end else if (quad_position == 2'd3) begin
            if (prior_sextet[1:0] != 2'd0) error_flag_next = 1'b1;
          end else begin
            error_flag_next = 1'b1;
          end
        end else if (pad_seen != 2'd1 || quad_position != 2'd3) begin
          error_flag_next = 1'b1;
        end
        pad_seen_next = pad_seen + 2'd1;
      end else if (sx.valid) begin
        if (pad_seen != 2'd0) begin
          error_flag_next = 1'b1;
        end else begin
          prior_sextet_next = sx.value;
          bit_store_next    = {bit_store[5:0], sx.value};
          bits_held_next    = bits_held + 4'd6;
          if (bits_held_next >= 4'd8) begin
            bits_held_next = bits_held_next - 4'd8;
            have_byte      = 1'b1;
          end
          shifted = 8'(bit_store_next >> bits_held_next);
        end
      end else begin
        error_flag_next = 1'b1;
      end
      if (fin && quad_position != 2'd3) error_flag_next = 1'b1;
    end
    res.byte_valid     = have_byte && !error_flag_next;
    res.data_byte      = res.byte_valid ? shifted : 8'd0;
    res.end_of_message = fin;
    res.failed         = fin && error_flag_next;
  end

  assign push = accept && (fin || res.byte_valid);

  // state update, cleared when a message closes
  always_ff @(posedge clk) begin
    if (rst || (accept && fin)) begin
      bit_store     <= '0;
      bits_held     <= '0;
      quad_position <= '0;
      pad_seen      <= '0;
      prior_sextet  <= '0;
      error_flag    <= 1'b0;
    end else if (accept && !error_flag) begin
      bit_store     <= bit_store_next;
      bits_held     <= bits_held_next;
      quad_position <= quad_position + 2'd1;
      pad_seen      <= pad_seen_next;
      prior_sextet  <= prior_sextet_next;
      error_flag    <= error_flag_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_item <= skid_valid ? skid_item : res;
    end else if (push) begin
      skid_item <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_item.data_byte;
  assign m_axis_tuser  = {out_item.failed, out_item.byte_valid};
  assign m_axis_tlast  = out_item.end_of_message;

endmodule

### rtl/b64sd_checker.sv
module b64sd_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // failure is only reported on the closing item
  a_fail_on_close: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("failed set on an item that does not close a message");

  // a failed message carries no byte on its closing item
  a_fail_no_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("byte delivered together with failure");

  // every item carries a byte or closes a message
  a_no_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tlast)
    else $error("item with neither byte nor close");

  // an item without a byte has zero data
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
    else $error("data nonzero without a byte");

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled item changed");

endmodule

bind base64_strict_decoder b64sd_checker u_b64sd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int ITEM_TARGET = 1850;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 10;

  // decoder state mirror and expected byte / close results
  class b64_scoreboard;
    logic [11:0]        bit_store;
    logic [3:0]         bits_held;
    logic [1:0]         quad_pos;
    logic [1:0]         pad_count;
    logic [5:0]         last_sextet;
    logic               bad;
    b64sd_pkg::result_t expected_q[$];
    int                 mismatches;

    function new();
      mismatches = 0;
      clear_message();
    endfunction

    function void clear_message();
      bit_store   = '0;
      bits_held   = '0;
      quad_pos    = '0;
      pad_count   = '0;
      last_sextet = '0;
      bad         = 1'b0;
    endfunction

    // alphabet lookup, returns 0 for characters outside the alphabet
    function logic alpha_value(input logic [7:0] c, output logic [5:0] v);
      v = '0;
      alpha_value = 1'b1;
      if (c inside {[8'h41:8'h5A]}) v = 6'(c - 8'h41);
      else if (c inside {[8'h61:8'h7A]}) v = 6'(c - 8'h61 + 8'd26);
      else if (c inside {[8'h30:8'h39]}) v = 6'(c - 8'h30 + 8'd52);
      else if (c == 8'h2B) v = 6'd62;
      else if (c == 8'h2F) v = 6'd63;
      else alpha_value = 1'b0;
    endfunction

    function void note_input(logic [7:0] sym, logic fin);
      b64sd_pkg::result_t r;
      logic [5:0]         v;
      logic [1:0]         pos;
      logic               have;
      logic [7:0]         b;
      logic [4:0]         held;
      pos  = quad_pos;
      have = 1'b0;
      b    = '0;
      if (!bad) begin
        if (sym == b64sd_pkg::PAD_CHAR) begin
          // padding may only close the final quad
          if (pad_count == 2'd0) begin
            case (pos)
              2'd2: if (last_sextet[3:0] != 4'd0) bad = 1'b1;
              2'd3: if (last_sextet[1:0] != 2'd0) bad = 1'b1;
              default: bad = 1'b1;
            endcase
          end else if (pad_count != 2'd1 || pos != 2'd3) begin
            bad = 1'b1;
          end
          pad_count = pad_count + 2'd1;
        end else if (alpha_value(sym, v)) begin
          if (pad_count != 2'd0) begin
            bad = 1'b1;
          end else begin
            last_sextet = v;
            bit_store   = {bit_store[5:0], v};
            held        = {1'b0, bits_held} + 5'd6;
            if (held >= 5'd8) begin
              held = held - 5'd8;
              b    = 8'(bit_store >> held);
              have = 1'b1;
            end
            bits_held = held[3:0];
          end
        end else begin
          bad = 1'b1;
        end
        if (fin && pos != 2'd3) bad = 1'b1;
        quad_pos = pos + 2'd1;
      end
      // a sticky error suppresses bytes, including the one on its own character
      if (bad) begin
        have = 1'b0;
        b    = '0;
      end
      if (fin || have) begin
        r.data_byte      = b;
        r.byte_valid     = have;
        r.end_of_message = fin;
        r.failed         = fin & bad;
        expected_q.insert(expected_q.size(), r);
      end
      if (fin) clear_message();
    endfunction

    function void check_result(logic [7:0] data_byte, logic byte_valid, logic eom,
                               logic failed);
      b64sd_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: byte=%02h valid=%0b eom=%0b failed=%0b",
                   data_byte, byte_valid, eom, failed);
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.data_byte !== data_byte || exp_r.byte_valid !== byte_valid ||
          exp_r.end_of_message !== eom || exp_r.failed !== failed) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"mismatch: exp byte=%02h valid=%0b eom=%0b failed=%0b, ",
                    "got byte=%02h valid=%0b eom=%0b failed=%0b"},
                   exp_r.data_byte, exp_r.byte_valid, exp_r.end_of_message, exp_r.failed,
                   data_byte, byte_valid, eom, failed);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  b64_scoreboard sb = new();
  int            items_sent = 0;
  int            cycle_count = 0;
  logic          calm_in = 1'b0;

  base64_strict_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one character, with a random hold-off before it
  task automatic send_char(input logic [7:0] sym, input logic fin);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(sym, fin);
    items_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    calm_in = ($urandom_range(0, 3) == 0);
    foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] msg[$];
    for (int i = 0; i < s.len(); i++) msg.insert(msg.size(), s[i]);
    send_message(msg);
  endtask

  function automatic logic [7:0] char_for(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return 8'h2B;
    return 8'h2F;
  endfunction

  // legal text: whole quads, optional padding with clean unused bits
  function automatic void build_legal(ref logic [7:0] msg[$]);
    int         quads;
    int         pads;
    logic [5:0] v;
    quads = $urandom_range(1, 5);
    pads  = $urandom_range(0, 2);
    msg.delete();
    for (int i = 0; i < quads * 4 - pads; i++) msg.insert(msg.size(), char_for(6'($urandom)));
    if (pads == 2) begin
      v = 6'($urandom);
      v[3:0] = 4'd0;
      msg[msg.size() - 1] = char_for(v);
      msg.insert(msg.size(), b64sd_pkg::PAD_CHAR);
      msg.insert(msg.size(), b64sd_pkg::PAD_CHAR);
    end else if (pads == 1) begin
      v = 6'($urandom);
      v[1:0] = 2'd0;
      msg[msg.size() - 1] = char_for(v);
      msg.insert(msg.size(), b64sd_pkg::PAD_CHAR);
    end
  endfunction

  // alter a legal text in one of several ways that may break it
  function automatic void corrupt(ref logic [7:0] msg[$]);
    int at;
    at = $urandom_range(0, msg.size() - 1);
    case ($urandom_range(0, 5))
      0: msg[at] = 8'($urandom);
      1: msg.insert(at, b64sd_pkg::PAD_CHAR);
      2: if (msg.size() > 1) msg.delete(at);
         else msg.insert(msg.size(), b64sd_pkg::PAD_CHAR);
      3: msg.insert(msg.size(), char_for(6'($urandom)));
      4: msg.insert(msg.size(), b64sd_pkg::PAD_CHAR);
      default: msg[at] = char_for(6'($urandom));
    endcase
  endfunction

  function automatic void build_noise(ref logic [7:0] msg[$]);
    int n;
    n = $urandom_range(1, 8);
    msg.delete();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: msg.insert(msg.size(), b64sd_pkg::PAD_CHAR);
        1: msg.insert(msg.size(), char_for(6'($urandom)));
        default: msg.insert(msg.size(), 8'($urandom));
      endcase
    end
  endfunction

  // result side, random stalls with calm stretches
  task automatic drain_results();
    int stall;
    int calm_left;
    calm_left = 0;
    forever begin
      if (calm_left > 0) begin
        calm_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 6);
        if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
    end
  endtask

  initial begin
    logic [7:0] msg[$];
    int         pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // directed: clean padding, dirty unused bits, misplaced padding,
    // data after padding, bad characters
    send_text("Zg==");
    send_text("Zm8=");
    send_text("Zh==");
    send_text("Zm9=");
    send_text("AA=A");
    send_text("=");
    msg = '{8'h2B, 8'h2F, 8'h00, 8'hFF};
    send_message(msg);

    // random messages, mostly legal
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        build_legal(msg);
        if (pick >= 60) corrupt(msg);
      end else begin
        build_noise(msg);
      end
      send_message(msg);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/b64sd_pkg.sv
rtl/base64_strict_decoder.sv
rtl/b64sd_checker.sv
sim/tb_top.sv
